// ===== design/four_channel_frame_with_crc16_core_macros.svh =====
// Assertion macros shared by the frame/CRC checker
`ifndef FOUR_CHANNEL_FRAME_WITH_CRC16_CORE_MACROS_SVH
`define FOUR_CHANNEL_FRAME_WITH_CRC16_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define FCRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define FCRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fcrc_pkg.sv =====
// Shared constants and the bytewise CRC-16/MODBUS update for the frame core
`timescale 1ns / 1ps

package fcrc_pkg;

  localparam int SampleW         = 16;
  localparam int ByteW           = 8;
  localparam int InFields        = 4;
  localparam int ChannelsDefault = 4;
  localparam int ChannelsMin     = 1;
  localparam int ChannelsMax     = 8;

  localparam logic [SampleW-1:0] CrcInit = 16'hFFFF;
  localparam logic [SampleW-1:0] CrcPoly = 16'hA001;

  // Fold one byte into the CRC, LSB first, one bit per step
  function automatic logic [SampleW-1:0] crc_byte(input logic [SampleW-1:0] crc,
                                                  input logic [ByteW-1:0]   data);
    logic [SampleW-1:0] c;
    c = crc ^ {{(SampleW-ByteW){1'b0}}, data};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/fcrc_stage.sv =====
// One pipeline stage: folds a single sample byte into the running CRC
`timescale 1ns / 1ps

module fcrc_stage #(
  parameter int CHANNELS = fcrc_pkg::ChannelsDefault,
  parameter int BYTE_IDX = 0
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic [CHANNELS-1:0][fcrc_pkg::SampleW-1:0] samples_i,
  input  logic [fcrc_pkg::SampleW-1:0]               crc_i,
  input  logic                                       ready_i,
  output logic                                       valid_o,
  output logic [CHANNELS-1:0][fcrc_pkg::SampleW-1:0] samples_o,
  output logic [fcrc_pkg::SampleW-1:0]               crc_o,
  output logic                                       ready_o
);
  import fcrc_pkg::*;

  localparam int Chan  = BYTE_IDX / 2;
  localparam int LowBit = ByteW * (BYTE_IDX % 2);

  logic                               valid_q;
  logic [CHANNELS-1:0][SampleW-1:0]   samples_q;
  logic [SampleW-1:0]                 crc_q;
  logic [SampleW-1:0]                 crc_d;
  logic [ByteW-1:0]                   cur_byte;

  // Pick this stage's byte and fold it in
  always_comb begin
    cur_byte = samples_i[Chan][LowBit +: ByteW];
    crc_d    = crc_byte(crc_i, cur_byte);
  end

  // Take a new request when empty or when the next stage drains this one
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold payload until the stage advances
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      samples_q <= samples_i;
      crc_q     <= crc_d;
    end
  end

  assign valid_o   = valid_q;
  assign samples_o = samples_q;
  assign crc_o     = crc_q;

endmodule

// ===== design/fcrc_ser.sv =====
// Output serialiser: holds one finished frame and emits it a byte per cycle
`timescale 1ns / 1ps

module fcrc_ser #(
  parameter int CHANNELS = fcrc_pkg::ChannelsDefault
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic [CHANNELS-1:0][fcrc_pkg::SampleW-1:0] samples_i,
  input  logic [fcrc_pkg::SampleW-1:0]               crc_i,
  output logic                                       ready_o,
  output logic                                       strobe_o,
  output logic [fcrc_pkg::ByteW-1:0]                 frame_byte_o,
  output logic                                       last_byte_o
);
  import fcrc_pkg::*;

  localparam int FrameLen = 2 * CHANNELS + 2;
  localparam int CntW     = $clog2(FrameLen);
  localparam logic [CntW-1:0] LastIdx = CntW'(FrameLen - 1);

  logic                             active_q;
  logic                             active_d;
  logic [CntW-1:0]                  cnt_q;
  logic [CntW-1:0]                  cnt_d;
  logic [CHANNELS-1:0][SampleW-1:0] samples_q;
  logic [SampleW-1:0]               crc_q;
  logic                             last_w;
  logic                             load_w;
  logic [FrameLen-1:0][ByteW-1:0]   frame_w;

  assign last_w  = active_q && (cnt_q == LastIdx);
  // Reload on the final byte so frames follow without a gap
  assign ready_o = !active_q || last_w;
  assign load_w  = ready_o && valid_i;

  // Advance the byte counter, reload or drop back to idle
  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (load_w) begin
      active_d = 1'b1;
      cnt_d    = '0;
    end else if (last_w) begin
      active_d = 1'b0;
    end else if (active_q) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_w) begin
      samples_q <= samples_i;
      crc_q     <= crc_i;
    end
  end

  // Lay out the frame: samples low byte first, then CRC low byte first
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      frame_w[2*c]     = samples_q[c][ByteW-1:0];
      frame_w[2*c + 1] = samples_q[c][SampleW-1:ByteW];
    end
    frame_w[FrameLen-2] = crc_q[ByteW-1:0];
    frame_w[FrameLen-1] = crc_q[SampleW-1:ByteW];
  end

  assign strobe_o     = active_q;
  assign frame_byte_o = frame_w[cnt_q];
  assign last_byte_o  = last_w;

endmodule

// ===== design/four_channel_frame_with_crc16_core.sv =====
// After start, a request passes the 2*CHANNELS CRC stages and is loaded into the serialiser; then one byte per cycle.
// Frames of 2*CHANNELS+2 bytes follow back to back, so the byte port sets the frame rate.
// The CRC pipeline of 2*CHANNELS stages buffers that many requests; busy rises when full.
// Results cannot be stalled: each byte shows for exactly one cycle under strobe_o.
// Reset (rst_ni, async, active low) empties the pipeline and the serialiser at once.
`timescale 1ns / 1ps

module four_channel_frame_with_crc16_core #(
  parameter int CHANNELS = fcrc_pkg::ChannelsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [fcrc_pkg::SampleW-1:0]  sample_0_i,
  input  logic [fcrc_pkg::SampleW-1:0]  sample_1_i,
  input  logic [fcrc_pkg::SampleW-1:0]  sample_2_i,
  input  logic [fcrc_pkg::SampleW-1:0]  sample_3_i,
  output logic                          strobe_o,
  output logic [fcrc_pkg::ByteW-1:0]    frame_byte_o,
  output logic                          last_byte_o
);
  import fcrc_pkg::*;

  // Clamp the channel count to the supported range
  localparam int Chans  = (CHANNELS < ChannelsMin) ? ChannelsMin :
                          (CHANNELS > ChannelsMax) ? ChannelsMax : CHANNELS;
  localparam int NStage = 2 * Chans;

  logic [InFields-1:0][SampleW-1:0]        in_w;
  logic [NStage:0]                         vld;
  logic [NStage:0]                         rdy;
  logic [NStage:0][Chans-1:0][SampleW-1:0] smp;
  logic [NStage:0][SampleW-1:0]            crc;

  assign in_w = {sample_3_i, sample_2_i, sample_1_i, sample_0_i};

  // Channels beyond the input fields carry zero
  for (genvar c = 0; c < Chans; c++) begin : g_chan
    if (c < InFields) begin : g_in
      assign smp[0][c] = in_w[c];
    end else begin : g_zero
      assign smp[0][c] = '0;
    end
  end

  assign vld[0] = start;
  assign crc[0] = CrcInit;
  assign busy   = !rdy[0];

  // One stage per sample byte
  for (genvar j = 0; j < NStage; j++) begin : g_stage
    fcrc_stage #(
      .CHANNELS (Chans),
      .BYTE_IDX (j)
    ) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (vld[j]),
      .samples_i (smp[j]),
      .crc_i     (crc[j]),
      .ready_i   (rdy[j+1]),
      .valid_o   (vld[j+1]),
      .samples_o (smp[j+1]),
      .crc_o     (crc[j+1]),
      .ready_o   (rdy[j])
    );
  end

  fcrc_ser #(
    .CHANNELS (Chans)
  ) u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (vld[NStage]),
    .samples_i    (smp[NStage]),
    .crc_i        (crc[NStage]),
    .ready_o      (rdy[NStage]),
    .strobe_o     (strobe_o),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

// ===== design/fcrc_checker.sv =====
// Port-level checks on frame framing, bound to the core
`timescale 1ns / 1ps
`include "four_channel_frame_with_crc16_core_macros.svh"

module fcrc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic strobe_o,
  input logic last_byte_o
);

  // The last marker only rides on a valid byte
  `FCRC_ASSERT_NOW(a_last_has_strobe, clk_i, rst_ni, last_byte_o, strobe_o, "last without strobe")
  // Bytes of one frame come out without a gap
  `FCRC_ASSERT_NEXT(a_frame_contiguous, clk_i, rst_ni, strobe_o && !last_byte_o, strobe_o, "gap in frame")
  // A frame is longer than one byte, so markers never sit back to back
  `FCRC_ASSERT_NEXT(a_no_double_last, clk_i, rst_ni, last_byte_o, !last_byte_o, "double last marker")
  // A block that shows nothing in flight takes a request
  `FCRC_ASSERT_NEXT(a_idle_not_busy, clk_i, rst_ni, !busy && !start && !strobe_o, !busy, "busy while idle")

endmodule

bind four_channel_frame_with_crc16_core fcrc_checker u_fcrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .strobe_o    (strobe_o),
  .last_byte_o (last_byte_o)
);
